### design/hfs_pkg.sv
package hfs_pkg;

   // Sizing of the window and delimiters
   localparam int MAX_PACKET  = 64;
   localparam int MAX_DELIM   = 8;
   localparam int BYTE_W      = 8;
   localparam int WIN_IDX_W   = $clog2(MAX_PACKET);
   localparam int LANE_W      = $clog2(MAX_DELIM);
   localparam int PAT_W       = MAX_DELIM * BYTE_W;
   localparam int PLEN_W      = 7;
   localparam int DLEN_W      = 4;
   localparam int COUNT_W     = 16;
   localparam int STATUS_W    = 2;

   // Configuration port
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PACKET_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_LENGTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FOOTER_LENGTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_PATTERN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FOOTER_PATTERN = 3'd4;

   // Reset values
   localparam logic [PLEN_W-1:0] PACKET_LENGTH_RESET = 7'd16;
   localparam logic [DLEN_W-1:0] HEADER_LENGTH_RESET = 4'd2;
   localparam logic [DLEN_W-1:0] FOOTER_LENGTH_RESET = 4'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_NEED_MORE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FOOTER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HEADER = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_GOOD       = 2'd3;

   // Effective (clamped) configuration seen by the datapath
   typedef struct packed {
      logic [PLEN_W-1:0] packet_length;
      logic [DLEN_W-1:0] header_length;
      logic [DLEN_W-1:0] footer_length;
      logic [PAT_W-1:0]  header_pattern;
      logic [PAT_W-1:0]  footer_pattern;
   } hfs_cfg_type;

   // One classified item on its way from front to back
   typedef struct packed {
      logic               need_more;
      logic               footer_bad;
      logic               header_bad;
      logic [PLEN_W-1:0]  missing;
      logic [PLEN_W-1:0]  packet_length;
      logic [DLEN_W-1:0]  footer_length;
      logic [COUNT_W-1:0] count;
   } hfs_entry_type;

endpackage

### design/hfs_regs.sv
module hfs_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hfs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hfs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hfs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output hfs_pkg::hfs_cfg_type           cfg
);
   import hfs_pkg::*;

   logic [PLEN_W-1:0]    plen_ff;
   logic [DLEN_W-1:0]    hlen_ff;
   logic [DLEN_W-1:0]    flen_ff;
   logic [PAT_W-1:0]     hpat_ff;
   logic [PAT_W-1:0]     fpat_ff;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;
   logic [PLEN_W-1:0]    plen_eff;
   logic [DLEN_W-1:0]    hlen_lim;
   logic [DLEN_W-1:0]    hlen_eff;
   logic [DLEN_W-1:0]    flen_eff;

   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Write registers on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= PACKET_LENGTH_RESET;
         hlen_ff <= HEADER_LENGTH_RESET;
         flen_ff <= FOOTER_LENGTH_RESET;
         hpat_ff <= '0;
         fpat_ff <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PACKET_LENGTH:  plen_ff <= pwdata[PLEN_W-1:0];
            REG_HEADER_LENGTH:  hlen_ff <= pwdata[DLEN_W-1:0];
            REG_FOOTER_LENGTH:  flen_ff <= pwdata[DLEN_W-1:0];
            REG_HEADER_PATTERN: hpat_ff <= pwdata[PAT_W-1:0];
            REG_FOOTER_PATTERN: fpat_ff <= pwdata[PAT_W-1:0];
            default: ;
         endcase
      end
   end

   // Return the stored value on reads
   always_comb begin
      case (reg_idx)
         REG_PACKET_LENGTH:  prdata = CSR_DATA_W'(plen_ff);
         REG_HEADER_LENGTH:  prdata = CSR_DATA_W'(hlen_ff);
         REG_FOOTER_LENGTH:  prdata = CSR_DATA_W'(flen_ff);
         REG_HEADER_PATTERN: prdata = CSR_DATA_W'(hpat_ff);
         REG_FOOTER_PATTERN: prdata = CSR_DATA_W'(fpat_ff);
         default:            prdata = '0;
      endcase
   end

   // Clamp lengths into their legal ranges
   always_comb begin
      if (plen_ff == '0) begin
         plen_eff = PLEN_W'(1);
      end else if (plen_ff > PLEN_W'(MAX_PACKET)) begin
         plen_eff = PLEN_W'(MAX_PACKET);
      end else begin
         plen_eff = plen_ff;
      end
      hlen_lim = (hlen_ff > DLEN_W'(MAX_DELIM)) ? DLEN_W'(MAX_DELIM) : hlen_ff;
      flen_eff = (flen_ff > DLEN_W'(MAX_DELIM)) ? DLEN_W'(MAX_DELIM) : flen_ff;
      hlen_eff = (PLEN_W'(hlen_lim) > plen_eff) ? plen_eff[DLEN_W-1:0] : hlen_lim;
   end

   assign cfg.packet_length  = plen_eff;
   assign cfg.header_length  = hlen_eff;
   assign cfg.footer_length  = flen_eff;
   assign cfg.header_pattern = hpat_ff;
   assign cfg.footer_pattern = fpat_ff;

endmodule

### design/hfs_front.sv
module hfs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  hfs_pkg::hfs_cfg_type       cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [hfs_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_start_new,
   input  logic                       q_ready,
   output logic                       q_push,
   output hfs_pkg::hfs_entry_type     q_entry
);
   import hfs_pkg::*;

   logic [BYTE_W-1:0]    win_ff [MAX_PACKET];
   logic [BYTE_W-1:0]    win_in [MAX_PACKET];
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [COUNT_W-1:0]   count_base;
   logic [COUNT_W-1:0]   count_new;
   logic                 need_more;
   logic [PLEN_W-1:0]    missing;
   logic [WIN_IDX_W-1:0] plen_m1;
   logic [MAX_DELIM-1:0] foot_miss;
   logic [MAX_PACKET-1:0] head_miss;
   logic                 accept;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign q_push    = accept;
   assign plen_m1   = WIN_IDX_W'(cfg.packet_length - PLEN_W'(1));

   // Shift the new byte into the window, newest at tap zero
   always_comb begin
      win_in[0] = req_data_byte;
      for (int k = 1; k < MAX_PACKET; k++) begin
         win_in[k] = win_ff[k-1];
      end
   end

   // Advance the saturating byte count
   always_comb begin
      count_base = req_start_new ? '0 : count_ff;
      count_new  = (count_base != {COUNT_W{1'b1}}) ? count_base + COUNT_W'(1) : count_base;
      need_more  = (count_new <= COUNT_W'(cfg.footer_length)) ||
                   (count_new < COUNT_W'(cfg.packet_length));
      missing    = (count_new < COUNT_W'(cfg.packet_length)) ?
                   PLEN_W'(cfg.packet_length - count_new[PLEN_W-1:0]) : '0;
      count_in   = need_more ? count_new : '0;
   end

   // Compare the footer against the newest bytes
   for (genvar i = 0; i < MAX_DELIM; i++) begin : g_foot
      assign foot_miss[i] = (DLEN_W'(i) < cfg.footer_length) &&
                            (win_in[i] != cfg.footer_pattern[i*BYTE_W +: BYTE_W]);
   end

   // Compare every tap against the header lane that lands on it
   for (genvar a = 0; a < MAX_PACKET; a++) begin : g_head
      localparam logic [WIN_IDX_W-1:0] TAP = WIN_IDX_W'(a);
      logic [WIN_IDX_W-1:0] off;
      logic                 chk;
      logic [LANE_W-1:0]    lane;
      assign off  = plen_m1 - TAP;
      assign lane = off[LANE_W-1:0];
      assign chk  = (TAP <= plen_m1) && (off < WIN_IDX_W'(cfg.header_length));
      assign head_miss[a] = chk && (win_in[a] != cfg.header_pattern[lane*BYTE_W +: BYTE_W]);
   end

   // Pack the classified item for the back end
   always_comb begin
      q_entry.need_more     = need_more;
      q_entry.footer_bad    = |foot_miss;
      q_entry.header_bad    = |head_miss;
      q_entry.missing       = missing;
      q_entry.packet_length = cfg.packet_length;
      q_entry.footer_length = cfg.footer_length;
      q_entry.count         = count_new;
   end

   // Hold window and count until an item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int k = 0; k < MAX_PACKET; k++) begin
            win_ff[k] <= '0;
         end
      end else if (accept) begin
         count_ff <= count_in;
         for (int k = 0; k < MAX_PACKET; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

endmodule

### design/hfs_queue.sv
module hfs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hfs_pkg::hfs_entry_type push_entry,
   output logic                   push_ready,
   input  logic                   pop,
   output logic                   pop_valid,
   output hfs_pkg::hfs_entry_type pop_entry
);
   import hfs_pkg::*;

   hfs_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff;
   logic [QCNT_W-1:0] fill_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + QCNT_W'(1);
         2'b01:   fill_in = fill_ff - QCNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/hfs_back.sv
module hfs_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  hfs_pkg::hfs_entry_type       q_entry,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hfs_pkg::STATUS_W-1:0] rsp_status,
   output logic [hfs_pkg::PLEN_W-1:0]   rsp_bytes_hint,
   output logic [hfs_pkg::COUNT_W-1:0]  rsp_frame_start
);
   import hfs_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [PLEN_W-1:0]   hint_ff;
   logic [PLEN_W-1:0]   hint_in;
   logic [COUNT_W-1:0]  start_ff;
   logic [COUNT_W-1:0]  start_in;
   logic                load;

   assign load  = q_valid && (!valid_ff || rsp_ready);
   assign q_pop = load;

   // Turn the classification into result fields
   always_comb begin
      start_in = '0;
      if (q_entry.need_more) begin
         status_in = STATUS_NEED_MORE;
         hint_in   = q_entry.missing;
      end else if (q_entry.footer_bad) begin
         status_in = STATUS_BAD_FOOTER;
         hint_in   = PLEN_W'(q_entry.footer_length);
      end else if (q_entry.header_bad) begin
         status_in = STATUS_BAD_HEADER;
         hint_in   = q_entry.packet_length;
      end else begin
         status_in = STATUS_GOOD;
         hint_in   = '0;
         start_in  = q_entry.count - COUNT_W'(q_entry.packet_length);
      end
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
   end

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         hint_ff   <= hint_in;
         start_ff  <= start_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_bytes_hint  = hint_ff;
   assign rsp_frame_start = start_ff;

endmodule

### design/sliding_header_footer_frame_sync_core.sv
// Fixed-length frame synchroniser with header and footer check.
// Request channel (req_valid/req_ready): one received byte per item, plus
// req_start_new to restart the byte count before this byte is counted.
// Response channel (rsp_valid/rsp_ready): exactly one result per item, with
// status (need more, bad footer, bad header, good), a bytes hint and the
// frame start offset when the frame is good.
// The front end shifts each byte into a 64-byte window, updates the count
// and runs all header and footer compares in the cycle the item is taken.
// The classified item goes through a two-entry queue to the back end, which
// forms the result in an output register.
// The accepted item is written into the queue, then loaded from the queue
// into the output register, which raises rsp_valid; a full output register
// holds it in the queue until rsp_ready lets the register be reloaded.
// Throughput: one item per cycle while the receiver keeps rsp_ready high.
// When the receiver stalls, the output register and the queue absorb up to
// three items before req_ready drops; it rises again as results drain.
// Reset clears the window to zero, the count to zero, empties the queue and
// loads the registers with their defaults (16, 2, 2, 0, 0).
// Registers sit on the APB-style port at byte addresses 8*index.
module sliding_header_footer_frame_sync_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [hfs_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           req_start_new,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [hfs_pkg::STATUS_W-1:0]   rsp_status,
   output logic [hfs_pkg::PLEN_W-1:0]     rsp_bytes_hint,
   output logic [hfs_pkg::COUNT_W-1:0]    rsp_frame_start,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hfs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hfs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hfs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import hfs_pkg::*;

   hfs_cfg_type   cfg;
   hfs_entry_type push_entry;
   hfs_entry_type pop_entry;
   logic          q_push;
   logic          q_ready;
   logic          q_pop;
   logic          q_valid;

   hfs_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hfs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_start_new (req_start_new),
      .q_ready       (q_ready),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   hfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   hfs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (pop_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_bytes_hint  (rsp_bytes_hint),
      .rsp_frame_start (rsp_frame_start)
   );

endmodule
